@@ src/ilh_pkg.sv @@
// shared types and constants of the interval log2 histogram
`timescale 1ns / 1ps

package ilh_pkg;

    // operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_PERIOD   = 2'd0,
        OP_UNDERRUN = 2'd1,
        OP_READ     = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SEARCH,
        ST_RDREQ,
        ST_RDWAIT,
        ST_FINISH
    } t_state;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned LAST_W  = 33;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 104;

endpackage

@@ src/ilh_log2_unit.sv @@
// iterative log2 bucket search, one doubling of the edge per cycle
`timescale 1ns / 1ps

module ilh_log2_unit #(
    parameter int unsigned BUCKETS = 16,
    parameter int unsigned BW      = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ilh_pkg::TIME_W-1:0] i_gap,
    output logic                       o_done,
    output logic [BW-1:0]              o_bucket
);

    localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);

    logic                       r_busy;
    logic [ilh_pkg::TIME_W-1:0] r_gap;
    logic [ilh_pkg::TIME_W:0]   r_edge;
    logic [BW-1:0]              r_bkt;
    logic                       step_on;

    // one compare per cycle: gap still reaches the edge and the cap is not hit
    assign step_on  = ({1'b0, r_gap} >= r_edge) && (r_bkt != LAST_BKT);
    assign o_done   = r_busy && !step_on;
    assign o_bucket = r_bkt;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    // search registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_gap  <= i_gap;
            r_edge <= (ilh_pkg::TIME_W + 1)'(1);
            r_bkt  <= '0;
        end else if (r_busy && step_on) begin
            r_edge <= {r_edge[ilh_pkg::TIME_W-1:0], 1'b0};
            r_bkt  <= r_bkt + BW'(1);
        end
    end

endmodule

@@ src/ilh_hist_mem.sv @@
// histogram counter memory with per-entry valid bits cleared at reset
`timescale 1ns / 1ps

module ilh_hist_mem #(
    parameter int unsigned BUCKETS = 16,
    parameter int unsigned BW      = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [BW-1:0]               i_rd_addr,
    output logic [ilh_pkg::COUNT_W-1:0] o_rd_data,
    input  logic                        i_wr_en,
    input  logic [BW-1:0]               i_wr_addr,
    input  logic [ilh_pkg::COUNT_W-1:0] i_wr_data
);

    logic [ilh_pkg::COUNT_W-1:0] r_mem [BUCKETS];
    logic [BUCKETS-1:0]          r_valid;
    logic [ilh_pkg::COUNT_W-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    // valid bits, an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

endmodule

@@ src/interval_log2_histogram.sv @@
// top level: sequencer, shared subtractor and result register of the monitor
`timescale 1ns / 1ps

// Interval log2 histogram monitor. Takes one timestamped event per beat
// (tuser: 0 period, 1 underrun, 2 read bucket) and returns one result beat
// per input beat. A period event runs a bucket search that doubles an edge
// once a cycle in a compare unit, then updates its counter. An underrun
// or the first period event skips search and memory, a bucket read only
// reads the counter, an unused op touches neither. The next event can be
// accepted once the result is loaded into the output register. The block
// takes one event at a time; a new event is accepted while the last
// result waits in the output register. Histogram counters sit in a small
// memory whose entries read as zero after reset until first written, so
// no clearing pass is needed. start_time is written through i_cfg_we and
// i_cfg_wdata, by the user only while the block is idle (not enforced).

module interval_log2_histogram #(
    parameter int unsigned BUCKETS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ilh_pkg::TIME_W-1:0]     i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] event_time, [35:32] read_index, [39:36] zero
    input  logic [ilh_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] op
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [3:0] bucket_index, [35:4] bucket_count, [36] bucket_updated,
    // [68:37] underrun_count, [101:69] underrun_last, [102] period_seen,
    // [103] zero
    output logic [ilh_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [5:0]  BUCKETS_6 = 6'(BUCKETS);

    ilh_pkg::t_state r_state, n_state;

    logic [ilh_pkg::TIME_W-1:0]  r_start;
    logic [ilh_pkg::TIME_W-1:0]  r_prev;
    logic                        r_prev_valid;
    logic [ilh_pkg::COUNT_W-1:0] r_under_total;
    logic [ilh_pkg::LAST_W-1:0]  r_under_last;
    logic                        r_seen;

    ilh_pkg::t_op                r_op;
    logic [ilh_pkg::TIME_W-1:0]  r_time;
    logic [ilh_pkg::IDX_W-1:0]   r_ridx;
    logic [BW-1:0]               r_bucket;
    logic [ilh_pkg::IDX_W-1:0]   r_bidx;
    logic [ilh_pkg::COUNT_W-1:0] r_bcount;
    logic                        r_bupd;
    logic                        r_out_valid;
    logic [ilh_pkg::OUT_DATA_W-1:0] r_out_data;

    logic                        in_beat;
    logic                        out_free;
    logic                        ridx_ok;
    logic [ilh_pkg::TIME_W-1:0]  sub_b;
    logic [ilh_pkg::TIME_W:0]    sub_full;
    logic [ilh_pkg::TIME_W-1:0]  sub_clamp;

    logic                        srch_start;
    logic                        srch_done;
    logic [BW-1:0]               srch_bucket;
    logic                        rd_en;
    logic [BW-1:0]               rd_addr;
    logic [ilh_pkg::COUNT_W-1:0] rd_data;
    logic                        wr_en;
    logic [ilh_pkg::COUNT_W-1:0] cnt_inc;

    assign out_free = !r_out_valid || m_axis_tready;
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign ridx_ok  = {2'b00, r_ridx} < BUCKETS_6;
    assign cnt_inc  = rd_data + ilh_pkg::COUNT_W'(1);

    // shared subtractor, clamped at zero on borrow
    assign sub_b     = (r_op == ilh_pkg::OP_PERIOD) ? r_prev : r_start;
    assign sub_full  = {1'b0, r_time} - {1'b0, sub_b};
    assign sub_clamp = sub_full[ilh_pkg::TIME_W] ? '0 : sub_full[ilh_pkg::TIME_W-1:0];

    ilh_log2_unit #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_log2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (srch_start),
        .i_gap    (sub_clamp),
        .o_done   (srch_done),
        .o_bucket (srch_bucket)
    );

    ilh_hist_mem #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_bucket),
        .i_wr_data (cnt_inc)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ilh_pkg::ST_IDLE: begin
                if (in_beat) begin
                    unique case (ilh_pkg::t_op'(s_axis_tuser))
                        ilh_pkg::OP_PERIOD,
                        ilh_pkg::OP_UNDERRUN: n_state = ilh_pkg::ST_DIFF;
                        ilh_pkg::OP_READ:     n_state = ilh_pkg::ST_RDREQ;
                        default:              n_state = ilh_pkg::ST_FINISH;
                    endcase
                end
            end
            ilh_pkg::ST_DIFF: begin
                if (r_op == ilh_pkg::OP_PERIOD && r_prev_valid) begin
                    n_state = ilh_pkg::ST_SEARCH;
                end else begin
                    n_state = ilh_pkg::ST_FINISH;
                end
            end
            ilh_pkg::ST_SEARCH: begin
                if (srch_done) begin
                    n_state = ilh_pkg::ST_RDREQ;
                end
            end
            ilh_pkg::ST_RDREQ: begin
                n_state = ilh_pkg::ST_RDWAIT;
            end
            ilh_pkg::ST_RDWAIT: begin
                n_state = ilh_pkg::ST_FINISH;
            end
            ilh_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = ilh_pkg::ST_IDLE;
                end
            end
            default: n_state = ilh_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        srch_start    = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = r_bucket;
        wr_en         = 1'b0;
        unique case (r_state)
            ilh_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ilh_pkg::ST_DIFF: begin
                srch_start = (r_op == ilh_pkg::OP_PERIOD) && r_prev_valid;
            end
            ilh_pkg::ST_RDREQ: begin
                rd_en = (r_op == ilh_pkg::OP_PERIOD) || ridx_ok;
                if (r_op != ilh_pkg::OP_PERIOD) begin
                    rd_addr = BW'(r_ridx);
                end
            end
            ilh_pkg::ST_RDWAIT: begin
                wr_en = (r_op == ilh_pkg::OP_PERIOD);
            end
            default: begin
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ilh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (i_cfg_we) begin
            r_start <= i_cfg_wdata;
        end
    end

    // monitor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= '0;
            r_prev_valid  <= 1'b0;
            r_under_total <= '0;
            r_under_last  <= '1;
            r_seen        <= 1'b0;
        end else begin
            if (r_state == ilh_pkg::ST_DIFF) begin
                if (r_op == ilh_pkg::OP_PERIOD) begin
                    r_prev       <= r_time;
                    r_prev_valid <= 1'b1;
                end else begin
                    r_under_total <= r_under_total + ilh_pkg::COUNT_W'(1);
                    r_under_last  <= {1'b0, sub_clamp};
                end
            end
            if (r_state == ilh_pkg::ST_RDWAIT && r_op == ilh_pkg::OP_PERIOD) begin
                r_seen <= 1'b1;
            end
        end
    end

    // working registers of the current item
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_op     <= ilh_pkg::t_op'(s_axis_tuser);
            r_time   <= s_axis_tdata[31:0];
            r_ridx   <= s_axis_tdata[35:32];
            r_bidx   <= (ilh_pkg::t_op'(s_axis_tuser) == ilh_pkg::OP_READ)
                        ? s_axis_tdata[35:32] : '0;
            r_bcount <= '0;
            r_bupd   <= 1'b0;
        end else if (r_state == ilh_pkg::ST_SEARCH && srch_done) begin
            r_bucket <= srch_bucket;
            r_bidx   <= ilh_pkg::IDX_W'(srch_bucket);
        end else if (r_state == ilh_pkg::ST_RDWAIT) begin
            if (r_op == ilh_pkg::OP_PERIOD) begin
                r_bcount <= cnt_inc;
                r_bupd   <= 1'b1;
            end else if (ridx_ok) begin
                r_bcount <= rd_data;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ilh_pkg::ST_FINISH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ilh_pkg::ST_FINISH && out_free) begin
            r_out_data <= {1'b0, r_seen, r_under_last, r_under_total,
                           r_bupd, r_bcount, r_bidx};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ test/interval_log2_histogram_check.sv @@
// checker of the interval log2 histogram: predicts every result beat and compares it
`timescale 1ns / 1ps

module interval_log2_histogram_check #(
    parameter int unsigned BUCKETS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ilh_pkg::TIME_W-1:0]     i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // [31:0] event_time, [35:32] read_index, [39:36] zero
    input  logic [ilh_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] op
    input  logic [1:0]                     s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [3:0] bucket_index, [35:4] bucket_count, [36] bucket_updated,
    // [68:37] underrun_count, [101:69] underrun_last, [102] period_seen,
    // [103] zero
    input  logic [ilh_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        logic [3:0]         bucket_index;
        logic [31:0]        bucket_count;
        logic               bucket_updated;
        logic [31:0]        underrun_count;
        logic signed [32:0] underrun_last;
        logic               period_seen;
    } t_status;

    // own copy of the monitor state
    logic [31:0]        start_ms;
    logic [31:0]        last_period_ms;
    logic               last_period_valid;
    logic [31:0]        interval_bins [BUCKETS];
    logic [31:0]        underrun_total;
    logic signed [32:0] underrun_ms;
    logic               intervals_seen;

    t_status awaited_results [$];
    int      mismatches = 0;
    int      awaited_count = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = awaited_count;

    // log2 bin of a gap: 0 stays 0, else index of top set bit plus one, capped
    function automatic int unsigned bin_of(input logic [31:0] gap);
        int unsigned b;
        b = 0;
        for (int i = 0; i < 32; i++) begin
            if (gap[i]) b = i + 1;
        end
        if (b > BUCKETS - 1) b = BUCKETS - 1;
        return b;
    endfunction

    // applies one event to the state and returns the status beat it causes
    function automatic t_status account_event(input ilh_pkg::t_op op,
                                              input logic [31:0] t,
                                              input logic [3:0] ridx);
        t_status     r;
        logic [31:0] gap;
        int unsigned bin;
        r = '0;
        case (op)
            ilh_pkg::OP_PERIOD: begin
                if (last_period_valid) begin
                    // a gap going backwards counts as zero
                    gap = (t >= last_period_ms) ? t - last_period_ms : 32'd0;
                    bin = bin_of(gap);
                    interval_bins[bin] = interval_bins[bin] + 32'd1;
                    intervals_seen = 1'b1;
                    r.bucket_index = bin[3:0];
                    r.bucket_count = interval_bins[bin];
                    r.bucket_updated = 1'b1;
                end
                last_period_ms = t;
                last_period_valid = 1'b1;
            end
            ilh_pkg::OP_UNDERRUN: begin
                underrun_total = underrun_total + 32'd1;
                // an underrun earlier than the start time clamps to zero
                underrun_ms = (t >= start_ms) ? {1'b0, t - start_ms} : 33'sd0;
            end
            ilh_pkg::OP_READ: begin
                r.bucket_index = ridx;
                if (ridx < BUCKETS) r.bucket_count = interval_bins[ridx];
            end
            default: begin
            end
        endcase
        r.underrun_count = underrun_total;
        r.underrun_last = underrun_ms;
        r.period_seen = intervals_seen;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [32:0] want,
                               input logic [32:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    // sample both channels and the register port at each rising edge
    always @(posedge i_clk) begin
        t_status want;
        t_status got;
        if (!i_rst_n) begin
            start_ms = '0;
            last_period_ms = '0;
            last_period_valid = 1'b0;
            for (int i = 0; i < BUCKETS; i++) interval_bins[i] = '0;
            underrun_total = '0;
            underrun_ms = -33'sd1;
            intervals_seen = 1'b0;
            awaited_results.delete();
        end else begin
            // result beat against the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                got.bucket_index   = m_axis_tdata[3:0];
                got.bucket_count   = m_axis_tdata[35:4];
                got.bucket_updated = m_axis_tdata[36];
                got.underrun_count = m_axis_tdata[68:37];
                got.underrun_last  = m_axis_tdata[101:69];
                got.period_seen    = m_axis_tdata[102];
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result beat with nothing expected, got %h",
                             $time, m_axis_tdata);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("bucket_index", want.bucket_index, got.bucket_index);
                    check_field("bucket_count", want.bucket_count, got.bucket_count);
                    check_field("bucket_updated", want.bucket_updated,
                                got.bucket_updated);
                    check_field("underrun_count", want.underrun_count,
                                got.underrun_count);
                    check_field("underrun_last", want.underrun_last, got.underrun_last);
                    check_field("period_seen", want.period_seen, got.period_seen);
                end
            end
            if (i_cfg_we) start_ms = i_cfg_wdata;
            // event beat: predict its status
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_results.push_back(account_event(ilh_pkg::t_op'(s_axis_tuser),
                                                        s_axis_tdata[31:0],
                                                        s_axis_tdata[35:32]));
            end
        end
        awaited_count = awaited_results.size();
    end

endmodule

@@ test/interval_log2_histogram_test.sv @@
// testbench top of the interval log2 histogram: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module interval_log2_histogram_test;

    localparam int unsigned BUCKETS     = 16;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          TAIL_CYCLES = 30;
    localparam int          PHASE_ITEMS = 113;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [ilh_pkg::TIME_W-1:0]     i_cfg_wdata = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [ilh_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]                     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [ilh_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          quiet_cycles = 0;
    logic [31:0] now_ms = '0;
    logic [31:0] phase_start [4];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    interval_log2_histogram #(.BUCKETS(BUCKETS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    interval_log2_histogram_check #(.BUCKETS(BUCKETS)) histogram_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // receiver back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("interval_log2_histogram verification failed");
                $finish;
            end
        end
    end

    // one event beat, with random idle cycles ahead of it
    task automatic send_event(input ilh_pkg::t_op op, input logic [31:0] t,
                              input logic [3:0] ridx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, ridx, t};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // start time written only once every result has come back
    task automatic write_start(input logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly rising period times with log-spread gaps, plus jumps and noise
    task automatic random_event();
        int          pick;
        int          shape;
        logic [31:0] t;
        pick = $urandom_range(99);
        if (pick < 50) begin
            shape = $urandom_range(9);
            if (shape < 8) now_ms = now_ms + ($urandom >> (32 - $urandom_range(32)));
            else if (shape == 9) now_ms = $urandom;
            send_event(ilh_pkg::OP_PERIOD, now_ms, 4'($urandom_range(15)));
        end else if (pick < 65) begin
            t = $urandom_range(1) ? now_ms : $urandom;
            send_event(ilh_pkg::OP_UNDERRUN, t, 4'($urandom_range(15)));
        end else if (pick < 93) begin
            send_event(ilh_pkg::OP_READ, $urandom, 4'($urandom_range(15)));
        end else begin
            send_event(ilh_pkg::OP_NONE, $urandom, 4'($urandom_range(15)));
        end
    endtask

    initial begin
        phase_start[0] = 32'h0000_0000;
        phase_start[1] = 32'hFFFF_FFFF;
        phase_start[2] = $urandom;
        phase_start[3] = $urandom;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_start(32'd1000);

        // directed: empty reads, first period, zero, backward and capped gaps
        send_event(ilh_pkg::OP_READ, 32'h0000_0000, 4'd0);
        send_event(ilh_pkg::OP_NONE, 32'hFFFF_FFFF, 4'd15);
        send_event(ilh_pkg::OP_PERIOD, 32'd100, 4'd0);
        send_event(ilh_pkg::OP_PERIOD, 32'd100, 4'd0);
        send_event(ilh_pkg::OP_PERIOD, 32'd101, 4'd0);
        send_event(ilh_pkg::OP_PERIOD, 32'd103, 4'd0);
        send_event(ilh_pkg::OP_PERIOD, 32'd50, 4'd0);
        send_event(ilh_pkg::OP_PERIOD, 32'hFFFF_FFFF, 4'd15);
        send_event(ilh_pkg::OP_PERIOD, 32'h0000_0000, 4'd0);
        send_event(ilh_pkg::OP_PERIOD, 32'h8000_0000, 4'd0);
        send_event(ilh_pkg::OP_PERIOD, 32'h8000_4000, 4'd0);
        send_event(ilh_pkg::OP_PERIOD, 32'h8000_7FFF, 4'd0);
        // underruns before, at and far after the start time
        send_event(ilh_pkg::OP_UNDERRUN, 32'd5, 4'd0);
        send_event(ilh_pkg::OP_UNDERRUN, 32'd1000, 4'd0);
        send_event(ilh_pkg::OP_UNDERRUN, 32'hFFFF_FFFF, 4'd15);
        send_event(ilh_pkg::OP_READ, 32'h0000_0000, 4'd15);
        send_event(ilh_pkg::OP_READ, 32'h0000_0000, 4'd0);
        send_event(ilh_pkg::OP_READ, 32'h0000_0000, 4'd14);
        send_event(ilh_pkg::OP_READ, 32'hFFFF_FFFF, 4'd1);
        send_event(ilh_pkg::OP_NONE, 32'h0000_0000, 4'd0);

        // random phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++) begin
            write_start(phase_start[phase]);
            send_idle_pct = (phase == 1) ? 53 : (phase == 3) ? 7 : 0;
            stall_pct     = (phase == 2) ? 53 : (phase == 3) ? 7 : 0;
            repeat (PHASE_ITEMS) random_event();
        end
        s_axis_tvalid <= 1'b0;

        // drain, then a short tail for stray beats
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("interval_log2_histogram verification clean");
        end else begin
            $display("interval_log2_histogram verification failed");
        end
        $finish;
    end

endmodule
